>>> src/assert_macros.svh
// Assertion macros for the checker module of the timer scheduler.
// No dependencies; expects signals clk and arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MTS_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("timer scheduler check failed");

// antecedent implies consequent in the next cycle
`define MTS_ASSERT_NXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("timer scheduler check failed");

`endif

>>> src/mts_pkg.sv
// Package for the timer scheduler: sizes, codes, command and status types.
// No dependencies.
package mts_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int TIME_BITS   = 48;
	localparam int PERIOD_BITS = 32;
	localparam int MAX_OUT     = 16;
	localparam int SLOT_W      = $clog2(NUM_TIMERS);
	localparam int CNT_OUT_W   = $clog2(MAX_OUT + 1);

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_ONESHOT = 3'd1,
		OP_SHARED  = 3'd2,
		OP_EXACT   = 3'd3,
		OP_CANCEL  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_FIRED     = 3'd0,
		ST_ACCEPTED  = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_NONE      = 3'd3,
		ST_FULL      = 3'd4,
		ST_BAD       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		K_ONESHOT = 2'd0,
		K_SHARED  = 2'd1,
		K_EXACT   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		A_NONE, A_START, A_SCAN_CLR, A_SCAN, A_FIRE, A_STEP, A_ALLOC, A_DIV_REG,
		A_ALLOC_SH, A_JOIN, A_CANCEL, A_FULL, A_BAD, A_NOEXP, A_EMIT
	} act_t;

	typedef enum logic [2:0] {
		SEL_SCAN, SEL_BEST, SEL_FREE, SEL_HIT, SEL_SID
	} sel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_SCAN, S_DECIDE, S_FIRE, S_DIV, S_NEXT,
		S_EMIT_MID, S_EMIT_END, S_CANCEL
	} state_t;

	typedef struct packed {
		act_t act;
		sel_t sel;
		logic last;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic found;
		logic pend;
		logic hit;
		logic hit_full;
		logic free;
		logic scan_last;
		logic oneshot;
		logic div_busy;
		logic n_max;
		logic cancel_ok;
		logic out_free;
	} sts_t;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [PERIOD_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + (TIME_BITS + 1)'(b);
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

endpackage

>>> src/multi_timer_scheduler.sv
// Timer slot scheduler top level: controller plus datapath.
// Depends on mts_pkg, mts_ctrl, mts_dp.
// One item at a time; in_ready is high only when idle.
// Tick: per fired slot one scan of all NUM_TIMERS slots plus a serial remainder
// step for periodic slots; the serial remainder unit and the slot scan set the rate.
// Reset clears time, valid bits and control at once; no clearing pass.
module multi_timer_scheduler import mts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] period,
	input  logic [3:0]  slot_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  timer_slot,
	output logic [47:0] fired_deadline,
	output logic        last
);

	cmd_t cmd;
	sts_t sts;

	mts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mts_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.period        (period),
		.slot_id       (slot_id),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.timer_slot    (timer_slot),
		.fired_deadline(fired_deadline),
		.last          (last)
	);

endmodule

>>> src/mts_div.sv
// Bit-serial remainder unit: a mod d, one dividend bit per cycle.
// Depends on mts_pkg.
module mts_div import mts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [TIME_BITS-1:0]   a,
	input  logic [PERIOD_BITS-1:0] d,
	output logic                   busy,
	output logic [PERIOD_BITS-1:0] rem
);

	localparam int CW = $clog2(TIME_BITS + 1);

	logic [TIME_BITS-1:0]   a_q;
	logic [PERIOD_BITS-1:0] d_q;
	logic [PERIOD_BITS-1:0] rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic [PERIOD_BITS:0]   trial;

	assign trial = {rem_q, a_q[TIME_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(TIME_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			if (trial >= {1'b0, d_q})
				rem_q <= PERIOD_BITS'(trial - {1'b0, d_q});
			else
				rem_q <= trial[PERIOD_BITS-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

>>> src/mts_dp.sv
// Datapath: slot table, time counter, scan registers, result and output registers.
// Depends on mts_pkg and mts_div.
module mts_dp import mts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [2:0]             opcode,
	input  logic [31:0]            period,
	input  logic [3:0]             slot_id,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [2:0]             status,
	output logic [3:0]             timer_slot,
	output logic [47:0]            fired_deadline,
	output logic                   last
);

	logic [NUM_TIMERS-1:0]  valid_q;
	logic [NUM_TIMERS-1:0]  done_q;
	kind_t                  kind_q  [NUM_TIMERS];
	logic [PERIOD_BITS-1:0] per_q   [NUM_TIMERS];
	logic [TIME_BITS-1:0]   dl_q    [NUM_TIMERS];
	logic [7:0]             users_q [NUM_TIMERS];

	op_t                    op_q;
	logic [PERIOD_BITS-1:0] p_q;
	logic [3:0]             sid_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [TIME_BITS-1:0]   s_q;
	logic [SLOT_W-1:0]      cnt_q, best_q, free_q, hit_q;
	logic [TIME_BITS-1:0]   best_dl_q;
	logic [7:0]             hit_users_q;
	logic                   found_q, free_found_q, hit_found_q, pend_q;
	logic [CNT_OUT_W-1:0]   n_q;
	status_t                res_status_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic [TIME_BITS-1:0]   res_dl_q;
	logic                   out_valid_q, last_q;
	status_t                status_q;
	logic [3:0]             slot_q;
	logic [TIME_BITS-1:0]   fdl_q;

	logic [SLOT_W-1:0]      idx;
	logic                   r_valid, r_done;
	kind_t                  r_kind;
	logic [PERIOD_BITS-1:0] r_per, p_in;
	logic [TIME_BITS-1:0]   r_dl;
	logic [7:0]             r_users;
	logic                   div_start, div_busy;
	logic [TIME_BITS-1:0]   div_a;
	logic [PERIOD_BITS-1:0] div_d, div_rem;

	always_comb begin
		unique case (cmd.sel)
			SEL_SCAN: idx = cnt_q;
			SEL_BEST: idx = best_q;
			SEL_FREE: idx = free_q;
			SEL_HIT:  idx = hit_q;
			default:  idx = SLOT_W'(sid_q);
		endcase
	end

	assign r_valid = valid_q[idx];
	assign r_done  = done_q[idx];
	assign r_kind  = kind_q[idx];
	assign r_per   = per_q[idx];
	assign r_dl    = dl_q[idx];
	assign r_users = users_q[idx];

	assign p_in = (PERIOD_BITS'(period) == '0) ? PERIOD_BITS'(1) : PERIOD_BITS'(period);

	assign div_start = (cmd.act == A_FIRE && r_kind != K_ONESHOT) || cmd.act == A_DIV_REG;
	assign div_a     = (cmd.act == A_FIRE) ? now_q - r_dl : sat_add(now_q, p_q);
	assign div_d     = (cmd.act == A_FIRE) ? r_per : p_q;

	mts_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a     (div_a),
		.d     (div_d),
		.busy  (div_busy),
		.rem   (div_rem)
	);

	// control flags and table valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			done_q       <= '0;
			now_q        <= '0;
			n_q          <= '0;
			pend_q       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.act == A_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (cmd.act)
				A_START: begin
					if (op_t'(opcode) == OP_TICK) begin
						now_q  <= sat_add(now_q, PERIOD_BITS'(1));
						done_q <= '0;
						n_q    <= '0;
						pend_q <= 1'b0;
					end
				end
				A_SCAN_CLR: begin
					cnt_q        <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					hit_found_q  <= 1'b0;
				end
				A_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (r_valid && !r_done && r_dl <= now_q &&
							(!found_q || r_dl < best_dl_q))
						found_q <= 1'b1;
					if (!r_valid)
						free_found_q <= 1'b1;
					if (r_valid && r_kind == K_SHARED && r_per == p_q)
						hit_found_q <= 1'b1;
				end
				A_FIRE: begin
					done_q[idx] <= 1'b1;
					n_q         <= n_q + 1'b1;
					pend_q      <= 1'b1;
					if (r_kind == K_ONESHOT)
						valid_q[idx] <= 1'b0;
				end
				A_ALLOC, A_ALLOC_SH: valid_q[idx] <= 1'b1;
				A_CANCEL: begin
					if (!(r_kind == K_SHARED && r_users > 8'd1))
						valid_q[idx] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload: slot fields, scan picks, result and output beat
	always_ff @(posedge clk) begin
		if (cmd.act == A_EMIT) begin
			status_q <= res_status_q;
			slot_q   <= 4'(res_slot_q);
			fdl_q    <= res_dl_q;
			last_q   <= cmd.last;
		end
		unique case (cmd.act)
			A_START: begin
				op_q  <= op_t'(opcode);
				p_q   <= p_in;
				sid_q <= slot_id;
			end
			A_SCAN: begin
				if (r_valid && !r_done && r_dl <= now_q && (!found_q || r_dl < best_dl_q)) begin
					best_q    <= cnt_q;
					best_dl_q <= r_dl;
				end
				if (!r_valid && !free_found_q)
					free_q <= cnt_q;
				if (r_valid && r_kind == K_SHARED && r_per == p_q && !hit_found_q) begin
					hit_q       <= cnt_q;
					hit_users_q <= r_users;
				end
			end
			A_FIRE: begin
				res_status_q <= ST_FIRED;
				res_slot_q   <= idx;
				res_dl_q     <= r_dl;
			end
			A_STEP: dl_q[idx] <= sat_add(now_q - TIME_BITS'(div_rem), r_per);
			A_ALLOC: begin
				kind_q[idx]  <= (op_q == OP_ONESHOT) ? K_ONESHOT : K_EXACT;
				per_q[idx]   <= p_q;
				dl_q[idx]    <= sat_add(now_q, p_q);
				users_q[idx] <= 8'd1;
				res_status_q <= ST_ACCEPTED;
				res_slot_q   <= idx;
				res_dl_q     <= now_q;
			end
			A_DIV_REG: s_q <= sat_add(now_q, p_q);
			A_ALLOC_SH: begin
				kind_q[idx]  <= K_SHARED;
				per_q[idx]   <= p_q;
				dl_q[idx]    <= s_q - TIME_BITS'(div_rem);
				users_q[idx] <= 8'd1;
				res_status_q <= ST_ACCEPTED;
				res_slot_q   <= idx;
				res_dl_q     <= now_q;
			end
			A_JOIN: begin
				users_q[idx] <= hit_users_q + 8'd1;
				res_status_q <= ST_ACCEPTED;
				res_slot_q   <= idx;
				res_dl_q     <= now_q;
			end
			A_CANCEL: begin
				if (r_kind == K_SHARED && r_users > 8'd1)
					users_q[idx] <= r_users - 8'd1;
				res_status_q <= ST_CANCELLED;
				res_slot_q   <= idx;
				res_dl_q     <= now_q;
			end
			A_FULL, A_BAD, A_NOEXP: begin
				res_status_q <= (cmd.act == A_FULL) ? ST_FULL :
						(cmd.act == A_BAD) ? ST_BAD : ST_NONE;
				res_slot_q   <= '0;
				res_dl_q     <= now_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.op        = op_q;
		sts.found     = found_q;
		sts.pend      = pend_q;
		sts.hit       = hit_found_q;
		sts.hit_full  = (hit_users_q == 8'hFF);
		sts.free      = free_found_q;
		sts.scan_last = (cnt_q == SLOT_W'(NUM_TIMERS - 1));
		sts.oneshot   = (r_kind == K_ONESHOT);
		sts.div_busy  = div_busy;
		sts.n_max     = (n_q == CNT_OUT_W'(MAX_OUT));
		sts.cancel_ok = (32'(sid_q) < NUM_TIMERS) && r_valid;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign timer_slot     = slot_q;
	assign fired_deadline = 48'(fdl_q);
	assign last           = last_q;

endmodule

>>> src/mts_ctrl.sv
// Controller: sequences scans, fires, remainder steps and result beats.
// Depends on mts_pkg.
module mts_ctrl import mts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (sts.op)
					OP_TICK, OP_ONESHOT, OP_SHARED, OP_EXACT: state_d = S_SCAN;
					OP_CANCEL: state_d = S_CANCEL;
					default:   state_d = S_IDLE;
				endcase
			end
			S_SCAN: if (sts.scan_last) state_d = S_DECIDE;
			S_DECIDE: begin
				if (sts.op == OP_TICK)
					state_d = !sts.found ? S_EMIT_END : (sts.pend ? S_EMIT_MID : S_FIRE);
				else if (sts.op == OP_SHARED && !sts.hit && sts.free)
					state_d = S_DIV;
				else
					state_d = S_EMIT_END;
			end
			S_FIRE: state_d = sts.oneshot ? S_NEXT : S_DIV;
			S_DIV: if (!sts.div_busy) state_d = (sts.op == OP_TICK) ? S_NEXT : S_EMIT_END;
			S_NEXT: state_d = sts.n_max ? S_EMIT_END : S_SCAN;
			S_EMIT_MID: if (sts.out_free) state_d = S_FIRE;
			S_EMIT_END: if (sts.out_free) state_d = S_IDLE;
			S_CANCEL: state_d = S_EMIT_END;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.act  = A_NONE;
		cmd.sel  = SEL_SID;
		cmd.last = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.act = A_START;
			S_DISP: if (sts.op != OP_CANCEL) cmd.act = A_SCAN_CLR;
			S_SCAN: begin
				cmd.act = A_SCAN;
				cmd.sel = SEL_SCAN;
			end
			S_DECIDE: begin
				if (sts.op == OP_TICK) begin
					if (!sts.found && !sts.pend)
						cmd.act = A_NOEXP;
				end else if (sts.op == OP_SHARED) begin
					if (sts.hit) begin
						cmd.act = sts.hit_full ? A_FULL : A_JOIN;
						cmd.sel = SEL_HIT;
					end else
						cmd.act = sts.free ? A_DIV_REG : A_FULL;
				end else begin
					cmd.act = sts.free ? A_ALLOC : A_FULL;
					cmd.sel = SEL_FREE;
				end
			end
			S_FIRE: begin
				cmd.act = A_FIRE;
				cmd.sel = SEL_BEST;
			end
			S_DIV: begin
				if (sts.op == OP_TICK) begin
					cmd.sel = SEL_BEST;
					if (!sts.div_busy) cmd.act = A_STEP;
				end else begin
					cmd.sel = SEL_FREE;
					if (!sts.div_busy) cmd.act = A_ALLOC_SH;
				end
			end
			S_NEXT: if (!sts.n_max) cmd.act = A_SCAN_CLR;
			S_EMIT_MID: if (sts.out_free) cmd.act = A_EMIT;
			S_EMIT_END: begin
				cmd.last = 1'b1;
				if (sts.out_free) cmd.act = A_EMIT;
			end
			S_CANCEL: cmd.act = sts.cancel_ok ? A_CANCEL : A_BAD;
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

>>> src/mts_chk.sv
// Port-level checker for the timer scheduler, bound to the top level.
// Depends on mts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mts_chk import mts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  opcode,
	input logic [31:0] period,
	input logic [3:0]  slot_id,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [3:0]  timer_slot,
	input logic [47:0] fired_deadline,
	input logic        last
);

	`MTS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`MTS_ASSERT_NXT(a_busy_mid_item, out_valid && out_ready && !last, !in_ready)
	`MTS_ASSERT_NOW(a_only_fired_not_last, out_valid && !last, status == ST_FIRED)
	`MTS_ASSERT_NOW(a_no_slot_on_fail, out_valid && (status == ST_NONE ||
		status == ST_FULL || status == ST_BAD), timer_slot == 4'd0)
	`MTS_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(status))

endmodule

bind multi_timer_scheduler mts_chk u_chk (.*);
